FILE: rtl/core/ctf_pkg.sv
package ctf_pkg;

    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 7;

    localparam int STEP_W    = $clog2(CORDIC_STEPS);
    localparam int CORDIC_W  = 36;
    localparam int ZANG_W    = 26;
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 32;

    localparam logic signed [ZANG_W-1:0] Z90 = ZANG_W'(90 * 65536);

    localparam logic [31:0]  GYRO_K     = 32'd3937335987;
    localparam logic [15:0]  ALPHA_INIT = 16'd64225;

    function automatic logic [21:0] atan_entry(input logic [4:0] idx);
        logic [21:0] v;
        unique case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/complementary_tilt_filter_unit.sv
// Takes an input sample only while idle and registers pitch and roll in the result register.
// No new sample is taken until the previous result is registered; pitch and roll share one
// CORDIC iteration unit and one 33x33 multiplier, run one after the other.
// The input side is ready again while the result register still waits for its sink.
// Reset (rst_n low, asynchronous): angles and last timestamp clear to zero,
// alpha returns to 64225, no result is pending.
module complementary_tilt_filter_unit
    import ctf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // accel_x, accel_y, accel_z, rate_x, rate_y (16 each), stamp_ms (32)
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // pitch (16), roll (16)
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_wdata
);

    typedef enum logic [3:0] {
        T_IDLE, T_CSTART, T_CWAIT, T_GP, T_GL, T_GH, T_GM, T_GG,
        T_BH, T_BL, T_BA, T_BF, T_BS, T_OUT
    } tstate_t;

    localparam int GSHIFT = 16 - ANGLE_FRAC_BITS;
    localparam int RSHIFT = 32 - ANGLE_FRAC_BITS;
    localparam logic signed [48:0] GCLAMP = 49'sd1 <<< 46;
    localparam logic signed [63:0] ROUND  = 64'sd1 <<< (31 - ANGLE_FRAC_BITS);

    tstate_t                    state_reg;
    logic                       sel_reg;
    logic signed [15:0]         ax_reg;
    logic signed [15:0]         ay_reg;
    logic signed [15:0]         az_reg;
    logic signed [15:0]         rx_reg;
    logic signed [15:0]         ry_reg;
    logic [31:0]                dt_reg;
    logic [31:0]                last_stamp_reg;
    logic signed [15:0]         pitch_reg;
    logic signed [15:0]         roll_reg;
    logic [15:0]                alpha_reg;
    logic signed [ZANG_W-1:0]   acc16_reg;
    logic signed [65:0]         prod_reg;
    logic [31:0]                p_hi_reg;
    logic [32:0]                lo_reg;
    logic [47:0]                mag_reg;
    logic                       neg_reg;
    logic signed [47:0]         g_reg;
    logic signed [63:0]         acc_reg;
    logic                       out_valid_reg;
    logic [M_TDATA_W-1:0]       out_data_reg;

    logic                       cordic_start;
    logic                       cordic_done;
    logic signed [ZANG_W-1:0]   cordic_angle;
    logic signed [16:0]         cordic_y;
    logic signed [16:0]         cordic_x;

    logic signed [15:0]         rate_sel;
    logic signed [15:0]         prev_sel;
    logic                       rate_neg;
    logic [16:0]                abs_rate;
    logic [16:0]                acc_wgt;
    logic signed [32:0]         mul_a;
    logic signed [32:0]         mul_b;
    logic signed [65:0]         mul_p;
    logic [48:0]                lo_sum;
    logic [32:0]                lo_next;
    logic [63:0]                mag_sum;
    logic [47:0]                mag_next;
    logic signed [48:0]         g_base;
    logic signed [48:0]         g_mag;
    logic signed [48:0]         g_sum;
    logic signed [47:0]         g_next;
    logic signed [63:0]         p64;
    logic signed [63:0]         r_shift;
    logic signed [15:0]         angle_next;

    assign s_axis_tready = (state_reg == T_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign cordic_start = (state_reg == T_CSTART);
    assign cordic_y     = sel_reg ? -17'(ax_reg) : 17'(ay_reg);
    assign cordic_x     = 17'(az_reg);

    ctf_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .y_in  (cordic_y),
        .x_in  (cordic_x),
        .done  (cordic_done),
        .angle (cordic_angle)
    );

    assign rate_sel = sel_reg ? ry_reg : rx_reg;
    assign prev_sel = sel_reg ? roll_reg : pitch_reg;
    assign rate_neg = rate_sel[15];
    assign abs_rate = rate_neg ? 17'(-17'(rate_sel)) : 17'(rate_sel);
    assign acc_wgt  = 17'd65536 - {1'b0, alpha_reg};

    always_comb
    begin
        unique case (state_reg)
            T_GP:
            begin
                mul_a = signed'({16'b0, abs_rate});
                mul_b = signed'({1'b0, dt_reg});
            end
            T_GL:
            begin
                mul_a = signed'({17'b0, prod_reg[15:0]});
                mul_b = signed'({1'b0, GYRO_K});
            end
            T_GH:
            begin
                mul_a = signed'({1'b0, p_hi_reg});
                mul_b = signed'({1'b0, GYRO_K});
            end
            T_BH:
            begin
                mul_a = 33'(signed'(g_reg[47:24]));
                mul_b = signed'({17'b0, alpha_reg});
            end
            T_BL:
            begin
                mul_a = signed'({9'b0, g_reg[23:0]});
                mul_b = signed'({17'b0, alpha_reg});
            end
            T_BA:
            begin
                mul_a = 33'(acc16_reg);
                mul_b = signed'({16'b0, acc_wgt});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign lo_sum   = prod_reg[48:0] + 49'd2147483648;
    assign lo_next  = lo_sum[48:16];
    assign mag_sum  = prod_reg[63:0] + {31'b0, lo_reg};
    assign mag_next = mag_sum[63:16];

    assign g_base = 49'(prev_sel) <<< GSHIFT;
    assign g_mag  = signed'({1'b0, mag_reg});
    assign g_sum  = neg_reg ? (g_base - g_mag) : (g_base + g_mag);

    always_comb
    begin
        if (g_sum > GCLAMP)
            g_next = 48'(GCLAMP);
        else if (g_sum < -GCLAMP)
            g_next = 48'(-GCLAMP);
        else
            g_next = g_sum[47:0];
    end

    assign p64     = prod_reg[63:0];
    assign r_shift = acc_reg >>> RSHIFT;

    always_comb
    begin
        if (r_shift > 64'sd32767)
            angle_next = 16'sh7FFF;
        else if (r_shift < -64'sd32768)
            angle_next = 16'sh8000;
        else
            angle_next = r_shift[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            alpha_reg <= ALPHA_INIT;
        else if (cfg_we)
            alpha_reg <= cfg_wdata;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= T_IDLE;
            sel_reg        <= 1'b0;
            last_stamp_reg <= '0;
            pitch_reg      <= '0;
            roll_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            ax_reg         <= '0;
            ay_reg         <= '0;
            az_reg         <= '0;
            rx_reg         <= '0;
            ry_reg         <= '0;
            dt_reg         <= '0;
            acc16_reg      <= '0;
            p_hi_reg       <= '0;
            lo_reg         <= '0;
            mag_reg        <= '0;
            neg_reg        <= 1'b0;
            g_reg          <= '0;
            acc_reg        <= '0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready && (state_reg != T_OUT))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                T_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        ax_reg         <= s_axis_tdata[15:0];
                        ay_reg         <= s_axis_tdata[31:16];
                        az_reg         <= s_axis_tdata[47:32];
                        rx_reg         <= s_axis_tdata[63:48];
                        ry_reg         <= s_axis_tdata[79:64];
                        dt_reg         <= s_axis_tdata[111:80] - last_stamp_reg;
                        last_stamp_reg <= s_axis_tdata[111:80];
                        sel_reg        <= 1'b0;
                        state_reg      <= T_CSTART;
                    end
                end
                T_CSTART: state_reg <= T_CWAIT;
                T_CWAIT:
                begin
                    if (cordic_done)
                    begin
                        acc16_reg <= cordic_angle;
                        state_reg <= T_GP;
                    end
                end
                T_GP:
                begin
                    neg_reg   <= rate_neg;
                    state_reg <= T_GL;
                end
                T_GL:
                begin
                    p_hi_reg  <= prod_reg[47:16];
                    state_reg <= T_GH;
                end
                T_GH:
                begin
                    lo_reg    <= lo_next;
                    state_reg <= T_GM;
                end
                T_GM:
                begin
                    mag_reg   <= mag_next;
                    state_reg <= T_GG;
                end
                T_GG:
                begin
                    g_reg     <= g_next;
                    state_reg <= T_BH;
                end
                T_BH: state_reg <= T_BL;
                T_BL:
                begin
                    acc_reg   <= p64 <<< 24;
                    state_reg <= T_BA;
                end
                T_BA:
                begin
                    acc_reg   <= acc_reg + p64;
                    state_reg <= T_BF;
                end
                T_BF:
                begin
                    acc_reg   <= acc_reg + p64 + ROUND;
                    state_reg <= T_BS;
                end
                T_BS:
                begin
                    if (sel_reg)
                    begin
                        roll_reg  <= angle_next;
                        state_reg <= T_OUT;
                    end
                    else
                    begin
                        pitch_reg <= angle_next;
                        sel_reg   <= 1'b1;
                        state_reg <= T_CSTART;
                    end
                end
                T_OUT:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_data_reg  <= {roll_reg, pitch_reg};
                        out_valid_reg <= 1'b1;
                        state_reg     <= T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/core/ctf_cordic.sv
module ctf_cordic
    import ctf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [16:0]       y_in,
    input  logic signed [16:0]       x_in,
    output logic                     done,
    output logic signed [ZANG_W-1:0] angle
);

    typedef enum logic {C_IDLE, C_RUN} cstate_t;

    cstate_t                     state_reg;
    logic signed [CORDIC_W-1:0]  x_reg;
    logic signed [CORDIC_W-1:0]  y_reg;
    logic signed [ZANG_W-1:0]    z_reg;
    logic [STEP_W-1:0]           step_reg;
    logic                        zero_reg;
    logic                        done_reg;
    logic signed [ZANG_W-1:0]    angle_reg;

    logic signed [CORDIC_W-1:0]  xs;
    logic signed [CORDIC_W-1:0]  ys;
    logic signed [CORDIC_W-1:0]  x_init;
    logic signed [CORDIC_W-1:0]  y_init;
    logic signed [ZANG_W-1:0]    z_init;
    logic signed [CORDIC_W-1:0]  dx;
    logic signed [CORDIC_W-1:0]  dy;
    logic signed [ZANG_W-1:0]    atan_z;
    logic                        y_pos;
    logic signed [CORDIC_W-1:0]  x_next;
    logic signed [CORDIC_W-1:0]  y_next;
    logic signed [ZANG_W-1:0]    z_next;

    assign xs = {{(CORDIC_W-33){x_in[16]}}, x_in, 16'b0};
    assign ys = {{(CORDIC_W-33){y_in[16]}}, y_in, 16'b0};

    // fold the left half plane into the right one
    always_comb
    begin
        if (x_in[16])
        begin
            if (!y_in[16])
            begin
                x_init = ys;
                y_init = -xs;
                z_init = Z90;
            end
            else
            begin
                x_init = -ys;
                y_init = xs;
                z_init = -Z90;
            end
        end
        else
        begin
            x_init = xs;
            y_init = ys;
            z_init = '0;
        end
    end

    assign dx     = y_reg >>> step_reg;
    assign dy     = x_reg >>> step_reg;
    assign atan_z = signed'({{(ZANG_W-22){1'b0}}, atan_entry(5'(step_reg))});
    assign y_pos  = !y_reg[CORDIC_W-1] && (y_reg != '0);

    always_comb
    begin
        if (y_pos)
        begin
            x_next = x_reg + dx;
            y_next = y_reg - dy;
            z_next = z_reg + atan_z;
        end
        else
        begin
            x_next = x_reg - dx;
            y_next = y_reg + dy;
            z_next = z_reg - atan_z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
            zero_reg  <= 1'b0;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            angle_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        x_reg     <= x_init;
                        y_reg     <= y_init;
                        z_reg     <= z_init;
                        zero_reg  <= (x_in == '0) && (y_in == '0);
                        step_reg  <= '0;
                        state_reg <= C_RUN;
                    end
                end
                C_RUN:
                begin
                    x_reg    <= x_next;
                    y_reg    <= y_next;
                    z_reg    <= z_next;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                    begin
                        angle_reg <= zero_reg ? '0 : z_next;
                        done_reg  <= 1'b1;
                        state_reg <= C_IDLE;
                    end
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule

FILE: rtl/core/ctf_checker.sv
module ctf_checker
    import ctf_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    // busy after every input transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input side ready right after a transaction");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a sample in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result dropped or changed");

    a_out_change_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(m_axis_tdata) |-> ($past(!s_axis_tready) && m_axis_tvalid))
        else $error("result data changed outside completion");

endmodule

bind complementary_tilt_filter_unit ctf_checker u_ctf_checker (.*);

FILE: tb/sv/tilt_filter_checker.sv
module tilt_filter_checker
    import ctf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    // accel_x, accel_y, accel_z, rate_x, rate_y (16 each), stamp_ms (32)
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // pitch (16), roll (16)
    input  logic [M_TDATA_W-1:0] m_axis_tdata,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_wdata,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic [31:0]        stamp_ms;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_x;
        logic signed [15:0] accel_z;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_x;
    } imu_sample_t;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
    } tilt_t;

    localparam int              OUT_SHIFT  = 32 - ANGLE_FRAC_BITS;
    localparam longint unsigned RAD_TO_DEG = 64'd3937335987;
    localparam longint          GYRO_LIMIT = longint'(1) << 46;
    localparam real             PI         = 3.14159265358979323846;

    logic signed [15:0] pitch_now;
    logic signed [15:0] roll_now;
    logic [31:0]        stamp_prev;
    logic [15:0]        gyro_weight;
    tilt_t              angle_q[$];

    imu_sample_t        smp;
    tilt_t              got;
    tilt_t              want;
    logic [31:0]        dt;

    function automatic longint atan_step(input int i);
        return longint'($atan(1.0 / (2.0 ** i)) * 65536.0 * 180.0 / PI);
    endfunction

    // atan2(num, den) in 2^-16 degree by vectoring rotations
    function automatic longint accel_tilt(input longint num, input longint den);
        longint xv;
        longint yv;
        longint zv;
        longint tv;
        longint dx;
        longint dy;
        if (num == 0 && den == 0)
        begin
            return 0;
        end
        xv = den * 65536;
        yv = num * 65536;
        zv = 0;
        if (xv < 0)
        begin
            if (yv >= 0)
            begin
                tv = xv;
                xv = yv;
                yv = -tv;
                zv = 90 * 65536;
            end
            else
            begin
                tv = xv;
                xv = -yv;
                yv = tv;
                zv = -90 * 65536;
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv > 0)
            begin
                xv = xv + dx;
                yv = yv - dy;
                zv = zv + atan_step(i);
            end
            else
            begin
                xv = xv - dx;
                yv = yv + dy;
                zv = zv - atan_step(i);
            end
        end
        return zv;
    endfunction

    function automatic longint gyro_delta(input logic signed [15:0] rate, input logic [31:0] span);
        longint          r;
        longint unsigned mag_rate;
        longint unsigned prod;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned mag;
        r = rate;
        mag_rate = (r < 0) ? -r : r;
        prod = mag_rate * {32'd0, span};
        hi = prod >> 16;
        lo = ((prod & 64'hFFFF) * RAD_TO_DEG + 64'h8000_0000) >> 16;
        mag = (hi * RAD_TO_DEG + lo) >> 16;
        return (r < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic logic signed [15:0] fuse_angle(input logic signed [15:0] prev,
                                                      input logic signed [15:0] rate,
                                                      input logic [31:0] span,
                                                      input longint acc,
                                                      input logic [15:0] w);
        longint g;
        longint a;
        longint sum;
        longint r;
        g = longint'(prev) * (longint'(1) << (16 - ANGLE_FRAC_BITS));
        g = g + gyro_delta(rate, span);
        if (g > GYRO_LIMIT)
        begin
            g = GYRO_LIMIT;
        end
        if (g < -GYRO_LIMIT)
        begin
            g = -GYRO_LIMIT;
        end
        a = longint'({48'd0, w});
        sum = a * g + (65536 - a) * acc;
        sum = sum + (longint'(1) << (OUT_SHIFT - 1));
        r = sum >>> OUT_SHIFT;
        if (r > 32767)
        begin
            r = 32767;
        end
        if (r < -32768)
        begin
            r = -32768;
        end
        return r[15:0];
    endfunction

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        fail_count++;
        if (fail_count <= 100)
        begin
            $display("mismatch %s: got %0d want %0d", what, got_v, want_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_now   = '0;
            roll_now    = '0;
            stamp_prev  = '0;
            gyro_weight = ALPHA_INIT;
            angle_q.delete();
            pending     = 0;
            fail_count  = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (angle_q.size() == 0)
                begin
                    report_mismatch("unexpected result", int'(got), 0);
                end
                else
                begin
                    want = angle_q.pop_front();
                    if (got.pitch !== want.pitch)
                    begin
                        report_mismatch("pitch", int'(got.pitch), int'(want.pitch));
                    end
                    if (got.roll !== want.roll)
                    begin
                        report_mismatch("roll", int'(got.roll), int'(want.roll));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                smp = s_axis_tdata;
                dt = smp.stamp_ms - stamp_prev;
                stamp_prev = smp.stamp_ms;
                pitch_now = fuse_angle(pitch_now, smp.rate_x, dt,
                                       accel_tilt(longint'(smp.accel_y), longint'(smp.accel_z)),
                                       gyro_weight);
                roll_now = fuse_angle(roll_now, smp.rate_y, dt,
                                      accel_tilt(-longint'(smp.accel_x), longint'(smp.accel_z)),
                                      gyro_weight);
                want.pitch = pitch_now;
                want.roll = roll_now;
                angle_q.push_back(want);
            end
            if (cfg_we)
            begin
                gyro_weight = cfg_wdata;
            end
            pending = angle_q.size();
        end
    end

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
    import ctf_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 cfg_we = 1'b0;
    logic [15:0]          cfg_wdata = '0;

    int                   fail_count;
    int                   pending;

    int                   burst_left = 0;
    logic [31:0]          stamp_now = '0;
    int                   rx_mode = 0;
    int                   rx_left = 0;
    int                   rx_hold = 0;

    complementary_tilt_filter_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    tilt_filter_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver: always ready, sparse stalls, or long on/off runs
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(50, 400);
        end
        rx_left--;
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default:
            begin
                if (rx_hold == 0)
                begin
                    rx_hold = $urandom_range(1, 80);
                    m_axis_tready <= ~m_axis_tready;
                end
                else
                begin
                    rx_hold--;
                end
            end
        endcase
    end

    task automatic push_sample(input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] az, input logic [15:0] rx,
                               input logic [15:0] ry, input logic [31:0] stamp);
        int gap_len;
        if (burst_left == 0)
        begin
            gap_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 90) : $urandom_range(0, 3);
            if (gap_len > 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap_len - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {stamp, ry, rx, az, ay, ax};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        stamp_now = stamp;
    endtask

    task automatic random_sample();
        int          mode;
        int          g;
        int          vx;
        int          vy;
        int          vz;
        logic [31:0] stamp;
        mode = $urandom_range(0, 19);
        if (mode < 2)
        begin
            push_sample(16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), $urandom);
        end
        else
        begin
            case (mode)
                2: stamp = stamp_now - $urandom_range(1, 5000);
                3: stamp = 32'hFFFF_FFFF - $urandom_range(0, 200);
                4: stamp = stamp_now;
                default: stamp = stamp_now + $urandom_range(1, 40);
            endcase
            g  = ($urandom_range(0, 9) == 0) ? -5020 : 5020;
            vx = $urandom_range(0, 10000) - 5000;
            vy = $urandom_range(0, 10000) - 5000;
            vz = g + $urandom_range(0, 2000) - 1000;
            if ($urandom_range(0, 15) == 0)
            begin
                vz = 0;
            end
            push_sample(vx[15:0], vy[15:0], vz[15:0],
                        16'($urandom_range(0, 4000) - 2000),
                        16'($urandom_range(0, 4000) - 2000), stamp);
        end
    endtask

    task automatic run_phase(input int n_items);
        repeat (n_items) random_sample();
    endtask

    task automatic settle();
        int n;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        n = 0;
        while (pending != 0 && n < 20000)
        begin
            @(negedge clk);
            n++;
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_alpha(input logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // first sample measures from zero, both accel inputs zero
        push_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd5);
        // zero first argument, negative second
        push_sample(16'd0, 16'd0, -16'sd4000, 16'd100, -16'sd100, 32'd10);
        // zero second argument, positive and negative first
        push_sample(16'd0, 16'd4000, 16'd0, 16'd0, 16'd0, 32'd20);
        push_sample(16'd4000, -16'sd4000, 16'd0, 16'd0, 16'd0, 32'd25);
        push_sample(16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 32'd30);
        push_sample(16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 32'd31);
        push_sample(16'h8000, 16'h8000, 16'hFFFF, 16'd1, 16'hFFFF, 32'd31);
        // stamp wraps forward, then steps backward
        push_sample(16'd0, 16'd100, 16'd5000, 16'h7FFF, 16'h8000, 32'hFFFF_FFF0);
        push_sample(16'd0, 16'd100, 16'd5000, 16'd500, 16'd500, 32'h0000_0008);
        push_sample(16'd0, 16'd0, 16'd5000, 16'd0, 16'd0, 32'd2);
        push_sample(16'd0, 16'd0, 16'd5000, 16'd1, 16'hFFFF, 32'd1);
        push_sample(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 32'd2);
        push_sample(16'hFFFF, 16'd0, 16'd1, 16'd0, 16'd0, 32'd3);
        run_phase(140);

        settle();
        write_alpha(16'd0);
        push_sample(16'd3000, 16'd3000, 16'd3000, 16'h7FFF, 16'h8000, stamp_now + 32'd10);
        push_sample(16'h8000, 16'h7FFF, 16'h8000, 16'd0, 16'd0, stamp_now + 32'd10);
        run_phase(140);

        settle();
        write_alpha(16'hFFFF);
        // huge gyro step, pushed into the clamp
        push_sample(16'd0, 16'd0, 16'd5000, 16'h7FFF, 16'h8000, stamp_now - 32'd1);
        push_sample(16'd0, 16'd0, 16'd5000, 16'h8000, 16'h7FFF, stamp_now - 32'd1);
        run_phase(140);

        settle();
        write_alpha(16'd32768);
        run_phase(140);

        settle();
        write_alpha(16'd1);
        run_phase(140);

        settle();
        write_alpha(16'($urandom));
        run_phase(140);

        settle();
        write_alpha(16'($urandom_range(60000, 65535)));
        run_phase(140);

        settle();
        write_alpha(ALPHA_INIT);
        run_phase(140);

        settle();
        repeat (80) @(negedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
